FILE: design/transverse_spherocity_engine_defines.svh
// assertion macros shared by the checker of the spherocity engine
// the including scope must provide i_clk and i_rst_n
`ifndef TRANSVERSE_SPHEROCITY_ENGINE_DEFINES_SVH
`define TRANSVERSE_SPHEROCITY_ENGINE_DEFINES_SVH

// checked only out of reset
`define TSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/tse_pkg.sv
// shared constants and codes of the transverse spherocity engine
// no dependencies
package tse_pkg;

    localparam int MAX_TRACKS = 256;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ANGLE_BITS = 12;
    localparam int QTR_BITS   = ANGLE_BITS - 2;
    localparam int WSUM_W     = 24;
    localparam int ACC_W      = 57;
    localparam int REM_W      = ACC_W + 1;
    localparam int Q_W        = 18;
    localparam int K_W        = $clog2(Q_W + 1);
    localparam int MUL_W      = 17;

    // quarter-wave sine polynomial, Q16
    localparam logic [MUL_W-1:0] POLY_A = 17'd102944;
    localparam logic [MUL_W-1:0] POLY_B = 17'd42048;
    localparam logic [MUL_W-1:0] POLY_C = 17'd4640;
    // pi^2/4 in Q16
    localparam logic [17:0]      PI2_Q16 = 18'd161704;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_FEW  = 3'd1,
        ST_ZERO_W   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_MIN_TRACKS  = 3'd0,
        CFG_MIN_PT      = 3'd1,
        CFG_ABS_ETA_MAX = 3'd2,
        CFG_PT_WEIGHTED = 3'd3,
        CFG_TRACK_MASK  = 3'd4
    } t_cfg_idx;

endpackage

FILE: design/tse_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/transverse_spherocity_engine.sv
// Transverse spherocity engine. Tracks arrive one transfer at a time on the slave stream and
// are taken only while the engine is idle. A track that passes the cuts while there is room is
// stored after one shared 17x17 multiplier evaluates the sine polynomial for cos and for sin
// (five steps each) and then forms the two weighted components. A rejected track is dropped
// without using the multiplier. After the last track of an event the axis search reads the
// direction memory once per candidate and streams the vector memory behind it, followed by a
// restoring divide and then squaring and scaling. The result may sit on the master stream
// while the next event is loaded. No clearing pass after reset.
// Depends on tse_pkg and tse_ram.
module transverse_spherocity_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // phi[11:0], pt[27:12], eta[39:28]
    input  logic [7:0]  s_axis_tuser,  // track_type[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // spherocity[15:0], accepted_count[24:16], zero[31:25]
    output logic [2:0]  m_axis_tuser,  // status[2:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SINE, S_WMUL, S_FINAL, S_AX_RD, S_AX_WT, S_ROW,
        S_DIV, S_SQ, S_MULK, S_VAL, S_OUT
    } t_state;

    localparam int IW = tse_pkg::IDX_W;
    localparam int CW = tse_pkg::CNT_W;

    t_state r_state;
    logic [2:0] r_step;

    // configuration
    logic [8:0]  r_min_tracks;
    logic [15:0] r_min_pt;
    logic [11:0] r_eta_max;
    logic        r_pt_weighted;
    logic [7:0]  r_mask;

    // event state
    logic [CW-1:0]                r_count;
    logic [tse_pkg::WSUM_W-1:0]   r_wsum;
    logic                         r_overflow;

    // track loading
    logic [tse_pkg::ANGLE_BITS-1:0] r_phi, r_ang;
    logic        r_sc, r_last;
    logic [15:0] r_w;
    logic [33:0] r_prod;
    logic [16:0] r_x2;
    logic signed [15:0] r_cos, r_sin;
    logic [31:0] r_wx;

    // axis search
    logic [CW-1:0] r_i, r_j;
    logic signed [15:0] r_ci, r_si;
    logic        r_v1, r_v2, r_v3;
    logic signed [47:0] r_p1, r_p2;
    logic [48:0] r_d;
    logic [tse_pkg::ACC_W-1:0] r_acc, r_best;

    // divide and scale
    logic [tse_pkg::REM_W-1:0] r_rem, r_dsh;
    logic [tse_pkg::Q_W-1:0]   r_q;
    logic [tse_pkg::K_W-1:0]   r_k;
    logic [35:0] r_r2, r_mlo, r_mhi;
    logic [15:0] r_sph;
    tse_pkg::t_status r_status;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_sph;
    logic [8:0]  r_out_count;
    logic [2:0]  r_out_status;

    // input fields
    logic [11:0] in_phi;
    logic [15:0] in_pt;
    logic [11:0] in_eta;
    logic [11:0] in_abs_eta;
    logic        in_keep;

    assign in_phi     = s_axis_tdata[11:0];
    assign in_pt      = s_axis_tdata[27:12];
    assign in_eta     = s_axis_tdata[39:28];
    assign in_abs_eta = in_eta[11] ? (~in_eta + 12'd1) : in_eta;
    assign in_keep    = (in_pt > r_min_pt) && (in_abs_eta < r_eta_max)
                        && ((s_axis_tuser & r_mask) == r_mask);

    // sine polynomial operands
    logic [1:0]                   sq_quad;
    logic [tse_pkg::QTR_BITS-1:0] sq_rem;
    logic [16:0] sq_x0, sq_x, pr_hi, sq_t;
    logic [17:0] sq_q, sq_half;
    logic [14:0] sq_s15;
    logic [15:0] sq_val;
    logic [16:0] mul_a, mul_b;
    logic [15:0] cos_neg, sin_neg;
    logic [14:0] cos_mag, sin_mag;
    logic [31:0] prod_neg, w_comp;

    assign sq_quad = r_ang[tse_pkg::ANGLE_BITS-1 -: 2];
    assign sq_rem  = r_ang[tse_pkg::QTR_BITS-1:0];
    assign sq_x0   = 17'(sq_rem) << (18 - tse_pkg::ANGLE_BITS);
    assign sq_x    = sq_quad[0] ? (17'd65536 - sq_x0) : sq_x0;
    assign pr_hi   = r_prod[32:16];
    assign sq_t    = (r_step == 3'd2) ? (tse_pkg::POLY_B - pr_hi) : (tse_pkg::POLY_A - pr_hi);
    assign sq_q    = r_prod[33:16];
    assign sq_half = (sq_q + 18'd1) >> 1;
    assign sq_s15  = (sq_half > 18'd32767) ? 15'h7fff : sq_half[14:0];
    assign sq_val  = sq_quad[1] ? (16'd0 - {1'b0, sq_s15}) : {1'b0, sq_s15};

    assign cos_neg  = 16'd0 - r_cos;
    assign sin_neg  = 16'd0 - r_sin;
    assign cos_mag  = r_cos[15] ? cos_neg[14:0] : r_cos[14:0];
    assign sin_mag  = r_sin[15] ? sin_neg[14:0] : r_sin[14:0];
    assign prod_neg = 32'd0 - r_prod[31:0];
    assign w_comp   = r_sin[15] ? prod_neg : r_prod[31:0];

    // one shared multiplier for loading
    always_comb begin
        mul_a = sq_x;
        mul_b = sq_x;
        if (r_state == S_SINE) begin
            case (r_step)
                3'd1:    begin mul_a = tse_pkg::POLY_C; mul_b = pr_hi;  end
                3'd2:    begin mul_a = sq_t;            mul_b = r_x2;   end
                3'd3:    begin mul_a = sq_t;            mul_b = sq_x;   end
                default: begin mul_a = sq_x;            mul_b = sq_x;   end
            endcase
        end else if (r_state == S_WMUL) begin
            mul_a = 17'(r_w);
            mul_b = (r_step == 3'd0) ? 17'(cos_mag) : 17'(sin_mag);
        end
    end

    // memories: written only while loading, read only while searching, so never both at once
    logic        mem_we;
    logic [31:0] ax_rd;
    logic [63:0] vec_rd;

    assign mem_we = (r_state == S_WMUL) && (r_step == 3'd2);

    tse_ram #(.WIDTH(32), .DEPTH(tse_pkg::MAX_TRACKS)) u_axis_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({r_sin, r_cos}),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (ax_rd)
    );

    tse_ram #(.WIDTH(64), .DEPTH(tse_pkg::MAX_TRACKS)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({w_comp, r_wx}),
        .i_raddr (r_j[IW-1:0]),
        .o_rdata (vec_rd)
    );

    // search datapath helpers
    logic signed [31:0] rd_wx, rd_wy;
    logic signed [48:0] row_diff;
    logic [48:0]        row_mag;
    logic [tse_pkg::ACC_W-1:0] n_best;
    logic [CW-1:0]      n_i;
    logic [24:0]        wsum_add;
    logic [55:0]        val_sum;
    logic [23:0]        val;

    assign rd_wx    = vec_rd[31:0];
    assign rd_wy    = vec_rd[63:32];
    assign row_diff = 49'(r_p1) - 49'(r_p2);
    assign row_mag  = row_diff[48] ? (49'd0 - row_diff) : row_diff;
    assign n_best   = (r_acc < r_best) ? r_acc : r_best;
    assign n_i      = r_i + CW'(1);
    assign wsum_add = 25'(r_wsum) + 25'(r_w);
    assign val_sum  = (56'(r_mhi) << 18) + 56'(r_mlo) + (56'd1 << 31);
    assign val      = val_sum[55:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= 3'd0;
            r_min_tracks  <= 9'd10;
            r_min_pt      <= 16'd200;
            r_eta_max     <= 12'd819;
            r_pt_weighted <= 1'b0;
            r_mask        <= 8'd0;
            r_count       <= '0;
            r_wsum        <= '0;
            r_overflow    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (tse_pkg::t_cfg_idx'(i_cfg_index))
                    tse_pkg::CFG_MIN_TRACKS:  r_min_tracks  <= i_cfg_data[8:0];
                    tse_pkg::CFG_MIN_PT:      r_min_pt      <= i_cfg_data;
                    tse_pkg::CFG_ABS_ETA_MAX: r_eta_max     <= i_cfg_data[11:0];
                    tse_pkg::CFG_PT_WEIGHTED: r_pt_weighted <= i_cfg_data[0];
                    tse_pkg::CFG_TRACK_MASK:  r_mask        <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // in S_OUT the output register is handled below
            if (r_out_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            r_prod <= mul_a * mul_b;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_last <= s_axis_tlast;
                        if (in_keep && !r_count[IW]) begin
                            r_phi   <= in_phi;
                            r_ang   <= in_phi + tse_pkg::ANGLE_BITS'(1 << tse_pkg::QTR_BITS);
                            r_sc    <= 1'b0;
                            r_step  <= 3'd0;
                            r_w     <= r_pt_weighted ? in_pt : 16'd1;
                            r_state <= S_SINE;
                        end else begin
                            if (in_keep) begin
                                r_overflow <= 1'b1;
                            end
                            if (s_axis_tlast) begin
                                r_state <= S_FINAL;
                            end
                        end
                    end
                end
                S_SINE: begin
                    r_step <= (r_step == 3'd4) ? 3'd0 : r_step + 3'd1;
                    if (r_step == 3'd1) begin
                        r_x2 <= pr_hi;
                    end
                    if (r_step == 3'd4) begin
                        if (!r_sc) begin
                            r_cos <= sq_val;
                            r_ang <= r_phi;
                            r_sc  <= 1'b1;
                        end else begin
                            r_sin   <= sq_val;
                            r_state <= S_WMUL;
                        end
                    end
                end
                S_WMUL: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd1) begin
                        r_wx <= r_cos[15] ? prod_neg : r_prod[31:0];
                    end
                    if (r_step == 3'd2) begin
                        r_count <= r_count + CW'(1);
                        r_wsum  <= wsum_add[24] ? '1 : wsum_add[23:0];
                        r_state <= r_last ? S_FINAL : S_IDLE;
                    end
                end
                S_FINAL: begin
                    r_sph <= 16'd0;
                    if (r_overflow) begin
                        r_status <= tse_pkg::ST_OVERFLOW;
                        r_state  <= S_OUT;
                    end else if (r_count < r_min_tracks) begin
                        r_status <= tse_pkg::ST_TOO_FEW;
                        r_state  <= S_OUT;
                    end else if (r_wsum == '0) begin
                        r_status <= tse_pkg::ST_ZERO_W;
                        r_state  <= S_OUT;
                    end else begin
                        r_i     <= '0;
                        r_best  <= '1;
                        r_state <= S_AX_RD;
                    end
                end
                S_AX_RD: begin
                    r_state <= S_AX_WT;
                end
                S_AX_WT: begin
                    r_ci    <= ax_rd[15:0];
                    r_si    <= ax_rd[31:16];
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_v1    <= 1'b0;
                    r_v2    <= 1'b0;
                    r_v3    <= 1'b0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    // read, multiply, magnitude, accumulate
                    r_v1 <= (r_j != r_count);
                    if (r_j != r_count) begin
                        r_j <= r_j + CW'(1);
                    end
                    r_v2 <= r_v1;
                    r_p1 <= r_si * rd_wx;
                    r_p2 <= r_ci * rd_wy;
                    r_v3 <= r_v2;
                    r_d  <= row_mag;
                    if (r_v3) begin
                        r_acc <= r_acc + tse_pkg::ACC_W'(r_d);
                    end
                    if (r_j == r_count && !r_v1 && !r_v2 && !r_v3) begin
                        r_best <= n_best;
                        r_i    <= n_i;
                        if (n_i == r_count) begin
                            r_rem   <= tse_pkg::REM_W'(n_best)
                                       + (tse_pkg::REM_W'(r_wsum) << 13);
                            r_dsh   <= tse_pkg::REM_W'(r_wsum) << (14 + tse_pkg::Q_W - 1);
                            r_q     <= '0;
                            r_k     <= tse_pkg::K_W'(tse_pkg::Q_W);
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_AX_RD;
                        end
                    end
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[tse_pkg::Q_W-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[tse_pkg::Q_W-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_k   <= r_k - tse_pkg::K_W'(1);
                    if (r_k == tse_pkg::K_W'(1)) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_r2    <= 36'(r_q) * 36'(r_q);
                    r_state <= S_MULK;
                end
                S_MULK: begin
                    r_mlo   <= 36'(r_r2[17:0]) * 36'(tse_pkg::PI2_Q16);
                    r_mhi   <= 36'(r_r2[35:18]) * 36'(tse_pkg::PI2_Q16);
                    r_state <= S_VAL;
                end
                S_VAL: begin
                    if (val > 24'd65536) begin
                        r_status <= tse_pkg::ST_RANGE;
                        r_sph    <= 16'd0;
                    end else begin
                        r_status <= tse_pkg::ST_OK;
                        r_sph    <= (val == 24'd65536) ? 16'hffff : val[15:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_sph    <= r_sph;
                        r_out_status <= r_status;
                        r_out_count  <= r_count;
                        r_count      <= '0;
                        r_wsum       <= '0;
                        r_overflow   <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_count, r_out_sph};
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: design/tse_checker.sv
// port-level checks on the result stream of the spherocity engine
// depends on tse_pkg and transverse_spherocity_engine_defines.svh; bound to the top level
`include "transverse_spherocity_engine_defines.svh"

module tse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    `TSE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid,
        "result valid after reset")
    `TSE_ASSERT(a_stall_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled result changed")
    `TSE_ASSERT(a_fail_zero,
        m_axis_tvalid && m_axis_tuser != tse_pkg::ST_OK |-> m_axis_tdata[15:0] == 16'd0,
        "spherocity nonzero on failed event")
    `TSE_ASSERT(a_ovf_full,
        m_axis_tvalid && m_axis_tuser == tse_pkg::ST_OVERFLOW
            |-> m_axis_tdata[24:16] == 9'(tse_pkg::MAX_TRACKS),
        "overflow without full store")
    `TSE_ASSERT(a_ok_tracks,
        m_axis_tvalid && m_axis_tuser == tse_pkg::ST_OK |-> m_axis_tdata[24:16] != 9'd0,
        "ok result with no tracks")

endmodule

bind transverse_spherocity_engine tse_checker u_tse_checker (.*);
